@@ design/sit_pkg.sv @@
// ----------------------------------------------------------------------------
// sit_pkg: shared types and constants of the session idle tracker
// Holds the table size, request and status codes, the session record layout
// and the timeout selection function.
// ----------------------------------------------------------------------------
package sit_pkg;

  // Table geometry.
  localparam int SESSION_COUNT = 1024;
  localparam int IDX_W         = $clog2(SESSION_COUNT);
  localparam int CNT_W         = $clog2(SESSION_COUNT + 1);
  localparam int SIDE_W        = IDX_W + 1;

  // Request codes.
  localparam logic [1:0] REQ_CREATE = 2'd0;
  localparam logic [1:0] REQ_TRACK  = 2'd1;
  localparam logic [1:0] REQ_CHECK  = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_ACCOUNTED = 3'd0;
  localparam logic [2:0] ST_CREATED   = 3'd1;
  localparam logic [2:0] ST_EXPIRED   = 3'd2;
  localparam logic [2:0] ST_RESTART   = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_FREE      = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] CFG_UDP   = 2'd0;
  localparam logic [1:0] CFG_EST   = 2'd1;
  localparam logic [1:0] CFG_TRANS = 2'd2;

  // Protocol numbers and TCP flag patterns for both sides.
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;
  localparam logic [15:0] FLAG_MASK = 16'h1717;
  localparam logic [15:0] FLAG_EST  = 16'h1212;

  // Per-session record kept in one memory word.
  typedef struct packed {
    logic        valid;
    logic [7:0]  proto;
    logic [15:0] flags;
  } meta_t;

  // Timeout registers.
  typedef struct packed {
    logic [63:0] udp;
    logic [63:0] est;
    logic [63:0] trans;
  } limits_t;

  // Timeout of a session from its protocol and seen flags.
  function automatic logic [63:0] limit_of(logic [7:0] proto, logic [15:0] flags,
                                           limits_t lim);
    logic [63:0] res;
    res = 64'd0;
    if (proto == PROTO_TCP) begin
      res = ((flags & FLAG_MASK) == FLAG_EST) ? lim.est : lim.trans;
    end else if (proto == PROTO_UDP) begin
      res = lim.udp;
    end
    return res;
  endfunction

endpackage

@@ design/sit_ram.sv @@
// ----------------------------------------------------------------------------
// sit_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/sit_alu.sv @@
// ----------------------------------------------------------------------------
// sit_alu: shared 64-bit adder and subtractor
// Adds or subtracts and reports the borrow, which doubles as an
// unsigned less-than compare.
// ----------------------------------------------------------------------------
module sit_alu (
  input  logic [63:0] a,
  input  logic [63:0] b,
  input  logic        sub,
  output logic [63:0] sum,
  output logic        borrow
);

  logic [64:0] full;

  // One wide add; subtraction through the inverted operand and carry in.
  assign full   = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {64'd0, sub};
  assign sum    = full[63:0];
  assign borrow = sub & ~full[64];

endmodule

@@ design/session_idle_tracker.sv @@
// ----------------------------------------------------------------------------
// session_idle_tracker: session table with idle timeout
// Each accepted request ends in one result strobe: a create (new, reused index or
// table full), a track or an expire check (live or expired), a free index or an
// unknown request.
// Throughput: one word at a time, busy high until the strobe cycle; the sequencer
// shares one 64-bit adder. Results cannot be stalled. Reset (rst_n low,
// synchronous) clears the counters and limits; entries at or above the high-water
// mark read as free.
// ----------------------------------------------------------------------------
module session_idle_tracker import sit_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [9:0]  in_entry_index,
  input  logic        in_direction,
  input  logic [7:0]  in_protocol,
  input  logic [7:0]  in_flag_byte,
  input  logic [15:0] in_packet_bytes,
  input  logic [63:0] in_time_now,
  output logic        out_valid,
  output logic [9:0]  out_result_index,
  output logic [2:0]  out_status,
  output logic        out_drop_packet,
  output logic [63:0] out_timer_due,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_CR_ALLOC, S_CR_POP, S_CR_W0, S_CR_W1,
    S_TK_RD, S_TK_MAX, S_TK_SUB, S_TK_CMP, S_TK_ACC, S_TK_BYT, S_CK_DUE
  } state_t;

  state_t             state_r;
  limits_t            lim_r;
  logic [1:0]         req_r;
  logic [IDX_W-1:0]   sess_r;
  logic               dir_r;
  logic [7:0]         proto_r;
  logic [7:0]         flag_r;
  logic [15:0]        bytes_r;
  logic [63:0]        now_r;
  logic [63:0]        last_r;
  logic [63:0]        diff_r;
  logic [CNT_W-1:0]   fcnt_r;
  logic [CNT_W-1:0]   hw_r;
  logic [CNT_W-1:0]   fcnt_dec;
  logic               out_valid_r;
  logic [9:0]         out_idx_r;
  logic [2:0]         out_status_r;
  logic               out_drop_r;
  logic [63:0]        out_due_r;

  logic               accept;
  logic               in_range;
  logic [15:0]        pkt_flags;
  logic [15:0]        tcp_flags;
  meta_t              meta_rd;
  meta_t              meta_wd;
  logic               meta_we;
  logic [63:0]        t0_rd;
  logic [63:0]        t1_rd;
  logic               t0_we;
  logic               t1_we;
  logic [63:0]        pkt_rd;
  logic [63:0]        byt_rd;
  logic               pkt_we;
  logic               byt_we;
  logic [63:0]        pkt_wd;
  logic [63:0]        byt_wd;
  logic [SIDE_W-1:0]  side_wa;
  logic               stk_we;
  logic [IDX_W-1:0]   stk_rd;
  logic               rd_en;
  logic [63:0]        lim;
  logic [63:0]        alu_a;
  logic [63:0]        alu_b;
  logic               alu_sub;
  logic [63:0]        alu_sum;
  logic               alu_borrow;
  logic               entry_live;

  assign accept    = start & ~busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_range  = (32'(in_entry_index) < SESSION_COUNT);
  assign fcnt_dec  = fcnt_r - 1'b1;
  assign entry_live = meta_rd.valid & (32'(sess_r) < 32'(hw_r));

  // Flags of this packet placed on its side, and the record's flags after it.
  assign pkt_flags = dir_r ? {flag_r, 8'h00} : {8'h00, flag_r};
  assign tcp_flags = (meta_rd.proto == PROTO_TCP) ? (meta_rd.flags | pkt_flags)
                                                  : meta_rd.flags;
  assign lim       = limit_of(meta_rd.proto, meta_rd.flags, lim_r);

  // Record memory write selection.
  always_comb begin
    meta_we = 1'b0;
    meta_wd = meta_rd;
    unique case (state_r)
      S_CR_W0: begin
        meta_we = 1'b1;
        meta_wd = '{valid: 1'b1, proto: proto_r,
                    flags: (proto_r == PROTO_TCP) ? pkt_flags : 16'h0000};
      end
      S_TK_CMP: begin
        meta_we       = ~alu_borrow;
        meta_wd.valid = 1'b0;
      end
      S_TK_BYT: begin
        meta_we       = 1'b1;
        meta_wd.flags = tcp_flags;
      end
      default: ;
    endcase
  end

  // Side time and counter write selection.
  always_comb begin
    t0_we   = 1'b0;
    t1_we   = 1'b0;
    pkt_we  = 1'b0;
    byt_we  = 1'b0;
    pkt_wd  = alu_sum;
    byt_wd  = alu_sum;
    side_wa = {sess_r, dir_r};
    stk_we  = 1'b0;
    unique case (state_r)
      S_CR_W0: begin
        t0_we  = 1'b1;
        t1_we  = 1'b1;
        pkt_we = 1'b1;
        byt_we = 1'b1;
        pkt_wd = 64'd1;
        byt_wd = {48'd0, bytes_r};
      end
      S_CR_W1: begin
        pkt_we  = 1'b1;
        byt_we  = 1'b1;
        pkt_wd  = 64'd0;
        byt_wd  = 64'd0;
        side_wa = {sess_r, ~dir_r};
      end
      S_TK_CMP: begin
        stk_we = ~alu_borrow & (32'(fcnt_r) < SESSION_COUNT);
      end
      S_TK_ACC: begin
        pkt_we = 1'b1;
      end
      S_TK_BYT: begin
        byt_we = 1'b1;
        t0_we  = ~dir_r;
        t1_we  = dir_r;
      end
      default: ;
    endcase
  end

  assign rd_en = (state_r == S_TK_RD);

  // Shared adder operand selection.
  always_comb begin
    alu_a   = now_r;
    alu_b   = last_r;
    alu_sub = 1'b0;
    unique case (state_r)
      S_CR_W0: begin
        alu_b = limit_of(proto_r, (proto_r == PROTO_TCP) ? pkt_flags : 16'h0000, lim_r);
      end
      S_TK_MAX: begin
        alu_a   = t0_rd;
        alu_b   = t1_rd;
        alu_sub = 1'b1;
      end
      S_TK_SUB: begin
        alu_sub = 1'b1;
      end
      S_TK_CMP: begin
        alu_a   = diff_r;
        alu_b   = lim;
        alu_sub = 1'b1;
      end
      S_TK_ACC: begin
        alu_a = pkt_rd;
        alu_b = 64'd1;
      end
      S_TK_BYT: begin
        alu_a = byt_rd;
        alu_b = {48'd0, bytes_r};
      end
      S_CK_DUE: begin
        alu_a = last_r;
        alu_b = lim;
      end
      default: ;
    endcase
  end

  sit_alu u_alu (
    .a(alu_a), .b(alu_b), .sub(alu_sub), .sum(alu_sum), .borrow(alu_borrow)
  );

  sit_ram #(.WIDTH($bits(meta_t)), .DEPTH(SESSION_COUNT)) u_meta (
    .clk(clk), .wr_en(meta_we), .wr_addr(sess_r), .wr_data(meta_wd),
    .rd_en(rd_en), .rd_addr(sess_r), .rd_data(meta_rd)
  );

  sit_ram #(.WIDTH(64), .DEPTH(SESSION_COUNT)) u_time0 (
    .clk(clk), .wr_en(t0_we), .wr_addr(sess_r), .wr_data(now_r),
    .rd_en(rd_en), .rd_addr(sess_r), .rd_data(t0_rd)
  );

  sit_ram #(.WIDTH(64), .DEPTH(SESSION_COUNT)) u_time1 (
    .clk(clk), .wr_en(t1_we), .wr_addr(sess_r), .wr_data(now_r),
    .rd_en(rd_en), .rd_addr(sess_r), .rd_data(t1_rd)
  );

  sit_ram #(.WIDTH(64), .DEPTH(2 * SESSION_COUNT)) u_pkt (
    .clk(clk), .wr_en(pkt_we), .wr_addr(side_wa), .wr_data(pkt_wd),
    .rd_en(rd_en), .rd_addr({sess_r, dir_r}), .rd_data(pkt_rd)
  );

  sit_ram #(.WIDTH(64), .DEPTH(2 * SESSION_COUNT)) u_byte (
    .clk(clk), .wr_en(byt_we), .wr_addr(side_wa), .wr_data(byt_wd),
    .rd_en(rd_en), .rd_addr({sess_r, dir_r}), .rd_data(byt_rd)
  );

  sit_ram #(.WIDTH(IDX_W), .DEPTH(SESSION_COUNT)) u_stack (
    .clk(clk), .wr_en(stk_we), .wr_addr(fcnt_r[IDX_W-1:0]), .wr_data(sess_r),
    .rd_en(state_r == S_CR_ALLOC), .rd_addr(fcnt_dec[IDX_W-1:0]), .rd_data(stk_rd)
  );

  // Sequencer, counters, configuration and result word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lim_r       <= '0;
      fcnt_r      <= '0;
      hw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_UDP:   lim_r.udp   <= cfg_data;
          CFG_EST:   lim_r.est   <= cfg_data;
          CFG_TRANS: lim_r.trans <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            req_r        <= in_req_type;
            sess_r       <= IDX_W'(in_entry_index);
            dir_r        <= in_direction;
            proto_r      <= in_protocol;
            flag_r       <= in_flag_byte;
            bytes_r      <= in_packet_bytes;
            now_r        <= in_time_now;
            out_idx_r    <= in_entry_index;
            out_status_r <= ST_FREE;
            out_drop_r   <= 1'b0;
            out_due_r    <= 64'd0;
            if (in_req_type == REQ_CREATE) begin
              state_r <= S_CR_ALLOC;
            end else if ((in_req_type == REQ_TRACK || in_req_type == REQ_CHECK)
                         && in_range) begin
              state_r <= S_TK_RD;
            end else begin
              out_drop_r  <= (in_req_type == REQ_TRACK);
              out_valid_r <= 1'b1;
            end
          end
        end
        S_CR_ALLOC: begin
          if (fcnt_r != '0) begin
            fcnt_r  <= fcnt_dec;
            state_r <= S_CR_POP;
          end else if (32'(hw_r) < SESSION_COUNT) begin
            sess_r  <= IDX_W'(hw_r);
            hw_r    <= hw_r + 1'b1;
            state_r <= S_CR_W0;
          end else begin
            out_idx_r    <= 10'd0;
            out_status_r <= ST_FULL;
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        S_CR_POP: begin
          sess_r  <= stk_rd;
          state_r <= S_CR_W0;
        end
        S_CR_W0: begin
          out_due_r <= alu_sum;
          state_r   <= S_CR_W1;
        end
        S_CR_W1: begin
          out_idx_r    <= 10'(sess_r);
          out_status_r <= ST_CREATED;
          out_valid_r  <= 1'b1;
          state_r      <= S_IDLE;
        end
        S_TK_RD: begin
          state_r <= S_TK_MAX;
        end
        S_TK_MAX: begin
          last_r <= alu_borrow ? t1_rd : t0_rd;
          if (entry_live) begin
            state_r <= S_TK_SUB;
          end else begin
            out_drop_r  <= (req_r == REQ_TRACK);
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_TK_SUB: begin
          diff_r  <= alu_sum;
          state_r <= S_TK_CMP;
        end
        S_TK_CMP: begin
          if (alu_borrow) begin
            state_r <= (req_r == REQ_TRACK) ? S_TK_ACC : S_CK_DUE;
          end else begin
            if (32'(fcnt_r) < SESSION_COUNT) begin
              fcnt_r <= fcnt_r + 1'b1;
            end
            out_status_r <= ST_EXPIRED;
            out_drop_r   <= (req_r == REQ_TRACK);
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        S_TK_ACC: begin
          state_r <= S_TK_BYT;
        end
        S_TK_BYT: begin
          out_status_r <= ST_ACCOUNTED;
          out_valid_r  <= 1'b1;
          state_r      <= S_IDLE;
        end
        S_CK_DUE: begin
          out_due_r    <= alu_sum;
          out_status_r <= ST_RESTART;
          out_valid_r  <= 1'b1;
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_index = out_idx_r;
  assign out_status       = out_status_r;
  assign out_drop_packet  = out_drop_r;
  assign out_timer_due    = out_due_r;

endmodule
